// ----- rtl/stereo_auto_gain_control_top_macros.svh -----
// assertion macros used by the gain control top level
`ifndef STEREO_AUTO_GAIN_CONTROL_TOP_MACROS_SVH
`define STEREO_AUTO_GAIN_CONTROL_TOP_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define SAGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define SAGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sagc_pkg.sv -----
// shared constants and types for the stereo gain control block
`timescale 1ns / 1ps

package sagc_pkg;

   localparam int SAMPLE_BITS_DEF = 24;

   // fixed-point formats
   localparam int ENV_W      = 40;   // envelope, q1.39
   localparam int GAIN_W     = 32;   // gain, q8.24
   localparam int GAIN_FRAC  = 24;
   localparam int COEF_W     = 25;   // coefficients, q0.24 up to 1.0
   localparam int COEF_FRAC  = 24;
   localparam int TARGET_W   = 17;   // target level, q0.16
   localparam int MAX_GAIN_W = 24;   // max gain, q8.16
   localparam int MAX_GAIN_SHIFT = GAIN_W - MAX_GAIN_W;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 25;

   // desired gain = (target << DIV_SHIFT) / envelope
   localparam int DIV_SHIFT    = 47;
   localparam int DIV_Q_W      = 34;
   localparam int DIV_PRESHIFT = DIV_SHIFT - DIV_Q_W;

   localparam logic [ENV_W-1:0]    ENV_THRESH = 40'd1099511628;
   localparam logic [ENV_W-1:0]    ENV_ONE    = {1'b1, {(ENV_W-1){1'b0}}};
   localparam logic [GAIN_W-1:0]   GAIN_ONE   = 32'h0100_0000;
   localparam logic [GAIN_W-1:0]   GAIN_FLOOR = 32'd3355443;
   localparam logic [TARGET_W-1:0] TARGET_MIN = 17'd3277;

   // register reset values
   localparam logic [TARGET_W-1:0]   TARGET_RST    = 17'd32768;
   localparam logic [MAX_GAIN_W-1:0] MAX_GAIN_RST  = 24'd207243;
   localparam logic [COEF_W-1:0]     ENV_COEF_RST  = 25'd1165;
   localparam logic [COEF_W-1:0]     GAIN_COEF_RST = 25'd233;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_LEVEL = 2'd0,
      CSR_MAX_GAIN     = 2'd1,
      CSR_ENV_COEF     = 2'd2,
      CSR_GAIN_COEF    = 2'd3
   } csr_index_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ----- rtl/stereo_auto_gain_control_top.sv -----
// stereo automatic gain control top level
// takes one stereo pair per transfer on req_, returns one gained pair per transfer on rsp_.
// the envelope follows the larger channel magnitude with a one-pole smoother; while it is
// above 0.002 the desired gain target / envelope is clamped to max_gain and to at least 0.2,
// and the stored gain glides toward it. both channels are then multiplied by the stored gain,
// rounded and saturated. one pair is processed at a time. the work is done by the serial
// units: the 24-step glide multiplier (used for the envelope and then the gain), the 34-step
// restoring divider, which runs only while the envelope is above the threshold, and the
// 32-step output multipliers (one per channel). a coefficient written as 1.0 skips its
// glide multiply. a finished pair sits in the rsp_ output register, so the next pair is
// taken while it waits. csr_ writes are always ready and are meant to arrive only while
// no pair is in flight; the envelope and gain are never touched by them. the envelope
// resets to 0 and the gain to 1.0.
`timescale 1ns / 1ps
`include "stereo_auto_gain_control_top_macros.svh"

module stereo_auto_gain_control_top #(
   parameter int SAMPLE_BITS = sagc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input pair
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_in_left,
   input  logic signed [SAMPLE_BITS-1:0]       req_in_right,
   input  logic                                req_block_end,
   // result pair
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_right,
   output logic [sagc_pkg::GAIN_W-1:0]         rsp_applied_gain,
   output logic                                rsp_block_end_out,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sagc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sagc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ENV_W     = sagc_pkg::ENV_W;
   localparam int GAIN_W    = sagc_pkg::GAIN_W;
   localparam int GAIN_FRAC = sagc_pkg::GAIN_FRAC;
   localparam int COEF_W    = sagc_pkg::COEF_W;
   localparam int COEF_FRAC = sagc_pkg::COEF_FRAC;
   localparam int TARGET_W  = sagc_pkg::TARGET_W;
   localparam int MG_W      = sagc_pkg::MAX_GAIN_W;
   localparam int Q_W       = sagc_pkg::DIV_Q_W;
   localparam int GMUL_W    = ENV_W + COEF_FRAC;
   localparam int OMUL_W    = SAMPLE_BITS + GAIN_W;
   // rounded output magnitude, with room for the rounding carry
   localparam int RND_W     = SAMPLE_BITS + GAIN_W - GAIN_FRAC + 1;
   localparam logic [RND_W-1:0] NEG_LIM = RND_W'(1) << (SAMPLE_BITS - 1);
   localparam logic [RND_W-1:0] POS_LIM = NEG_LIM - RND_W'(1);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_ENV_PREP  = 10'b00_0000_0010,
      ST_ENV_MUL   = 10'b00_0000_0100,
      ST_CHECK     = 10'b00_0000_1000,
      ST_DIV       = 10'b00_0001_0000,
      ST_GAIN_PREP = 10'b00_0010_0000,
      ST_GAIN_MUL  = 10'b00_0100_0000,
      ST_OUT_START = 10'b00_1000_0000,
      ST_OUT_MUL   = 10'b01_0000_0000,
      ST_RESULT    = 10'b10_0000_0000
   } state_type;

   // control and state registers
   state_type            state_ff, state_in;
   logic [ENV_W-1:0]     env_ff, env_in;
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [TARGET_W-1:0]  target_ff, target_in;
   logic [MG_W-1:0]      max_gain_ff, max_gain_in;
   logic [COEF_W-1:0]    env_coef_ff, env_coef_in;
   logic [COEF_W-1:0]    gain_coef_ff, gain_coef_in;

   // payload registers
   logic [SAMPLE_BITS-1:0] left_ff, left_in;
   logic [SAMPLE_BITS-1:0] right_ff, right_in;
   logic                   blk_end_ff, blk_end_in;
   logic                   dir_up_ff, dir_up_in;
   logic [SAMPLE_BITS-1:0] out_left_ff, out_left_in;
   logic [SAMPLE_BITS-1:0] out_right_ff, out_right_in;
   logic [GAIN_W-1:0]      out_gain_ff, out_gain_in;
   logic                   out_end_ff, out_end_in;

   // sample magnitudes and envelope glide
   logic                   neg_left, neg_right;
   logic [SAMPLE_BITS-1:0] mag_left, mag_right, mag_max;
   logic [ENV_W-1:0]       mag_env;
   logic                   env_up;
   logic [ENV_W-1:0]       env_diff;

   // desired gain and gain glide
   logic [TARGET_W-1:0]    target_eff;
   logic [GAIN_W-1:0]      gain_limit;
   logic [GAIN_W-1:0]      desired_lim;
   logic [GAIN_W-1:0]      desired;
   logic                   gain_up;
   logic [GAIN_W-1:0]      gain_diff;

   // serial units
   logic                      glide_start;
   logic [ENV_W-1:0]          glide_a;
   logic [COEF_FRAC-1:0]      glide_b;
   sagc_pkg::unit_status_type glide_status;
   logic [GMUL_W-1:0]         glide_prod;
   logic [ENV_W-1:0]          glide_step;

   logic                      div_start;
   sagc_pkg::unit_status_type div_status;
   logic [Q_W-1:0]            quotient;

   logic                      out_start;
   sagc_pkg::unit_status_type left_status, right_status;
   logic [OMUL_W-1:0]         left_prod, right_prod;

   // output rounding and saturation
   logic [RND_W-1:0]       rnd_left, rnd_right;
   logic [RND_W-1:0]       clip_left, clip_right;
   logic [SAMPLE_BITS-1:0] res_left, res_right;
   logic                   rsp_load;

   // magnitude of each channel; the most negative sample gives exactly 1.0
   always_comb begin
      neg_left  = left_ff[SAMPLE_BITS-1];
      neg_right = right_ff[SAMPLE_BITS-1];
      mag_left  = neg_left ? (~left_ff + SAMPLE_BITS'(1)) : left_ff;
      mag_right = neg_right ? (~right_ff + SAMPLE_BITS'(1)) : right_ff;
      mag_max   = (mag_right > mag_left) ? mag_right : mag_left;
      mag_env   = {mag_max, {(ENV_W-SAMPLE_BITS){1'b0}}};
      env_up    = mag_env >= env_ff;
      env_diff  = env_up ? (mag_env - env_ff) : (env_ff - mag_env);
   end

   // desired gain from the divider quotient, clamped to max gain and then to the floor
   always_comb begin
      target_eff  = (target_ff < sagc_pkg::TARGET_MIN) ? sagc_pkg::TARGET_MIN : target_ff;
      gain_limit  = {max_gain_ff, {sagc_pkg::MAX_GAIN_SHIFT{1'b0}}};
      desired_lim = (quotient > {{(Q_W-GAIN_W){1'b0}}, gain_limit}) ? gain_limit
                                                                      : quotient[GAIN_W-1:0];
      desired     = (desired_lim < sagc_pkg::GAIN_FLOOR) ? sagc_pkg::GAIN_FLOOR : desired_lim;
      gain_up     = desired >= gain_ff;
      gain_diff   = gain_up ? (desired - gain_ff) : (gain_ff - desired);
   end

   // step = (diff * coef) >> 24, truncated
   assign glide_step = glide_prod[COEF_FRAC +: ENV_W];

   // round half away from zero on the magnitude, then restore the sign and saturate
   always_comb begin
      rnd_left   = {1'b0, left_prod[OMUL_W-1:GAIN_FRAC]} + RND_W'(left_prod[GAIN_FRAC-1]);
      rnd_right  = {1'b0, right_prod[OMUL_W-1:GAIN_FRAC]} + RND_W'(right_prod[GAIN_FRAC-1]);
      if (neg_left) begin
         clip_left = (rnd_left > NEG_LIM) ? NEG_LIM : rnd_left;
         res_left  = ~clip_left[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
      end else begin
         clip_left = (rnd_left > POS_LIM) ? POS_LIM : rnd_left;
         res_left  = clip_left[SAMPLE_BITS-1:0];
      end
      if (neg_right) begin
         clip_right = (rnd_right > NEG_LIM) ? NEG_LIM : rnd_right;
         res_right  = ~clip_right[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
      end else begin
         clip_right = (rnd_right > POS_LIM) ? POS_LIM : rnd_right;
         res_right  = clip_right[SAMPLE_BITS-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      env_in      = env_ff;
      gain_in     = gain_ff;
      dir_up_in   = dir_up_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      blk_end_in  = blk_end_ff;
      glide_start = 1'b0;
      glide_a     = '0;
      glide_b     = '0;
      div_start   = 1'b0;
      out_start   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               left_in    = req_in_left;
               right_in   = req_in_right;
               blk_end_in = req_block_end;
               state_in   = ST_ENV_PREP;
            end
         end
         ST_ENV_PREP: begin
            dir_up_in = env_up;
            if (env_coef_ff[COEF_W-1]) begin
               // coefficient of one or more jumps straight to the magnitude
               env_in   = mag_env;
               state_in = ST_CHECK;
            end else begin
               glide_start = 1'b1;
               glide_a     = env_diff;
               glide_b     = env_coef_ff[COEF_FRAC-1:0];
               state_in    = ST_ENV_MUL;
            end
         end
         ST_ENV_MUL: begin
            if (glide_status.done) begin
               env_in   = dir_up_ff ? (env_ff + glide_step) : (env_ff - glide_step);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (env_ff > sagc_pkg::ENV_THRESH) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               // quiet input holds the gain
               state_in = ST_OUT_START;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_GAIN_PREP;
            end
         end
         ST_GAIN_PREP: begin
            dir_up_in = gain_up;
            if (gain_coef_ff[COEF_W-1]) begin
               gain_in  = desired;
               state_in = ST_OUT_START;
            end else begin
               glide_start = 1'b1;
               glide_a     = {{(ENV_W-GAIN_W){1'b0}}, gain_diff};
               glide_b     = gain_coef_ff[COEF_FRAC-1:0];
               state_in    = ST_GAIN_MUL;
            end
         end
         ST_GAIN_MUL: begin
            if (glide_status.done) begin
               gain_in  = dir_up_ff ? (gain_ff + glide_step[GAIN_W-1:0])
                                    : (gain_ff - glide_step[GAIN_W-1:0]);
               state_in = ST_OUT_START;
            end
         end
         ST_OUT_START: begin
            out_start = 1'b1;
            state_in  = ST_OUT_MUL;
         end
         ST_OUT_MUL: begin
            if (left_status.done && right_status.done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      out_left_in  = rsp_load ? res_left : out_left_ff;
      out_right_in = rsp_load ? res_right : out_right_ff;
      out_gain_in  = rsp_load ? gain_ff : out_gain_ff;
      out_end_in   = rsp_load ? blk_end_ff : out_end_ff;
   end

   // configuration writes
   always_comb begin
      target_in    = target_ff;
      max_gain_in  = max_gain_ff;
      env_coef_in  = env_coef_ff;
      gain_coef_in = gain_coef_ff;
      if (csr_valid) begin
         unique case (sagc_pkg::csr_index_type'(csr_index))
            sagc_pkg::CSR_TARGET_LEVEL: target_in    = csr_wdata[TARGET_W-1:0];
            sagc_pkg::CSR_MAX_GAIN:     max_gain_in  = csr_wdata[MG_W-1:0];
            sagc_pkg::CSR_ENV_COEF:     env_coef_in  = csr_wdata[COEF_W-1:0];
            sagc_pkg::CSR_GAIN_COEF:    gain_coef_in = csr_wdata[COEF_W-1:0];
            default: begin
               target_in = target_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         gain_ff      <= sagc_pkg::GAIN_ONE;
         rsp_valid_ff <= 1'b0;
         target_ff    <= sagc_pkg::TARGET_RST;
         max_gain_ff  <= sagc_pkg::MAX_GAIN_RST;
         env_coef_ff  <= sagc_pkg::ENV_COEF_RST;
         gain_coef_ff <= sagc_pkg::GAIN_COEF_RST;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         max_gain_ff  <= max_gain_in;
         env_coef_ff  <= env_coef_in;
         gain_coef_ff <= gain_coef_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      blk_end_ff   <= blk_end_in;
      dir_up_ff    <= dir_up_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_gain_ff  <= out_gain_in;
      out_end_ff   <= out_end_in;
   end

   // shared glide multiplier: envelope first, then gain
   sagc_mul #(
      .A_W (ENV_W),
      .B_W (COEF_FRAC)
   ) u_glide_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (glide_start),
      .a       (glide_a),
      .b       (glide_b),
      .status  (glide_status),
      .product (glide_prod)
   );

   sagc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .target   (target_eff),
      .divisor  (env_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   // per-channel output multipliers, magnitude times gain
   sagc_mul #(
      .A_W (SAMPLE_BITS),
      .B_W (GAIN_W)
   ) u_left_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (out_start),
      .a       (mag_left),
      .b       (gain_ff),
      .status  (left_status),
      .product (left_prod)
   );

   sagc_mul #(
      .A_W (SAMPLE_BITS),
      .B_W (GAIN_W)
   ) u_right_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (out_start),
      .a       (mag_right),
      .b       (gain_ff),
      .status  (right_status),
      .product (right_prod)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_left      = out_left_ff;
   assign rsp_out_right     = out_right_ff;
   assign rsp_applied_gain  = out_gain_ff;
   assign rsp_block_end_out = out_end_ff;
   assign csr_ready         = 1'b1;

   // envelope never passes full scale
   `SAGC_ASSERT_NOW(env_range_chk, clock, reset, 1'b1, env_ff <= sagc_pkg::ENV_ONE, "envelope above full scale")
   // gain glides only between values at or above the floor
   `SAGC_ASSERT_NOW(gain_floor_chk, clock, reset, 1'b1, gain_ff >= sagc_pkg::GAIN_FLOOR, "gain below floor")
   // no serial unit still running once a new pair can be taken
   `SAGC_ASSERT_NOW(idle_units_chk, clock, reset, req_ready, !glide_status.busy && !div_status.busy && !left_status.busy && !right_status.busy, "unit busy while idle")
   // division only runs above the envelope threshold
   `SAGC_ASSERT_NOW(div_thresh_chk, clock, reset, div_start, env_ff > sagc_pkg::ENV_THRESH, "divide below threshold")
   // a loaded result shows up on the port
   `SAGC_ASSERT_NEXT(rsp_load_chk, clock, reset, rsp_load, rsp_valid && (rsp_applied_gain == $past(gain_ff)), "result not presented")

endmodule

// ----- rtl/sagc_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module sagc_mul #(
   parameter int A_W = sagc_pkg::ENV_W,
   parameter int B_W = sagc_pkg::COEF_FRAC
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [A_W-1:0]            a,
   input  logic [B_W-1:0]            b,
   output sagc_pkg::unit_status_type status,
   output logic [A_W+B_W-1:0]        product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]   a_ff, a_in;
   logic [A_W-1:0]   hi_ff, hi_in;
   logic [B_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [A_W:0]     sum;

   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : {(A_W+1){1'b0}});
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add on the low multiplier bit, then shift the product right
         hi_in  = sum[A_W:1];
         lo_in  = {sum[0], lo_ff[B_W-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = {hi_ff, lo_ff};

endmodule

// ----- rtl/sagc_div.sv -----
// restoring divider for the desired gain, one quotient bit per cycle
`timescale 1ns / 1ps

module sagc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [sagc_pkg::TARGET_W-1:0]       target,
   input  logic [sagc_pkg::ENV_W-1:0]          divisor,
   output sagc_pkg::unit_status_type           status,
   output logic [sagc_pkg::DIV_Q_W-1:0]        quotient
);

   localparam int ENV_W = sagc_pkg::ENV_W;
   localparam int Q_W   = sagc_pkg::DIV_Q_W;
   localparam int CNT_W = $clog2(Q_W + 1);
   localparam int PAD_W = ENV_W - sagc_pkg::TARGET_W - sagc_pkg::DIV_PRESHIFT;

   logic [ENV_W-1:0] rem_ff, rem_in;
   logic [ENV_W-1:0] div_ff, div_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ENV_W:0]   shifted;
   logic [ENV_W:0]   trial;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
      rem_in  = rem_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // top dividend bits; below them the dividend is all zeros
         rem_in  = {{PAD_W{1'b0}}, target, {sagc_pkg::DIV_PRESHIFT{1'b0}}};
         div_in  = divisor;
         q_in    = '0;
         cnt_in  = CNT_W'(Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[ENV_W-1:0] : shifted[ENV_W-1:0];
         q_in   = {q_ff[Q_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule
